// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of the duty ramp block.
// Expects i_clk and i_rst_n (synchronous, active low) in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is held.
`define RGBDR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked property that is also checked during reset.
`define RGBDR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== sv/rgbdr_pkg.sv =====
// Types and codes of the RGB duty ramp generator.
// No dependencies; used by the stream interface users and the core.
`default_nettype none

package rgbdr_pkg;

    localparam int DUTY_BITS      = 8;
    localparam int STEP_BITS      = 12;
    localparam int RATE_BITS      = 8;
    localparam int STEP_FRAC_BITS = 8;
    localparam int NUM_CH         = 3;
    localparam int CFG_IDX_BITS   = 2;

    typedef logic [DUTY_BITS-1:0] t_duty;
    typedef logic [STEP_BITS-1:0] t_step;
    typedef logic [RATE_BITS-1:0] t_rate;
    typedef logic [1:0]           t_chan;
    typedef logic [1:0]           t_mode;
    typedef logic                 t_op;
    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    localparam t_op OP_TICK  = 1'b0;
    localparam t_op OP_START = 1'b1;

    localparam t_chan CH_NONE  = 2'd0;
    localparam t_chan CH_RED   = 2'd1;
    localparam t_chan CH_GREEN = 2'd2;
    localparam t_chan CH_BLUE  = 2'd3;

    localparam t_mode MODE_STOP = 2'd0;
    localparam t_mode MODE_UP   = 2'd1;
    localparam t_mode MODE_DOWN = 2'd2;

    localparam t_cfg_idx CFG_RATE_RED   = 2'd0;
    localparam t_cfg_idx CFG_RATE_GREEN = 2'd1;
    localparam t_cfg_idx CFG_RATE_BLUE  = 2'd2;

    localparam t_duty RED_RESET = t_duty'(80);

    typedef struct packed {
        t_op   operation;
        t_chan channel;
        t_mode mode;
        t_duty target;
        t_step step_size;
    } t_in_item;

    typedef struct packed {
        t_duty duty_red;
        t_duty duty_green;
        t_duty duty_blue;
        logic  busy_res;
        logic  finished;
    } t_out_item;

endpackage

`default_nettype wire

// ===== sv/rgbdr_stream_if.sv =====
// Valid/ready stream channel carrying one payload beat per handshake.
// Payload type is a parameter; no other dependencies.
`default_nettype none

interface rgbdr_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/rgb_duty_ramp_generator_core.sv =====
// Top level of the RGB duty ramp generator: ramp state, rate registers
// and the result register. Uses rgbdr_pkg, rgbdr_stream_if, assert_macros.svh.
//
//   channel   | direction | beat contents
//   ----------+-----------+-----------------------------------------------
//   i_item    | in        | operation, channel, mode, target, step_size
//   o_result  | out       | duty_red, duty_green, duty_blue, busy_res, finished
//   i_cfg_*   | in        | rate write: index 0 red, 1 green, 2 blue
//
// Each accepted beat updates the ramp state and loads the result register at the
// same edge; a beat may be accepted every cycle while the result register is empty or being taken.
// The single multiply, add and compare for the active channel sets the path.
// i_item.ready is high while the result register is empty or being taken.
// Reset (synchronous) sets red duty to 80, others to 0, no ramp active.
`default_nettype none
`include "assert_macros.svh"

module rgb_duty_ramp_generator_core
    import rgbdr_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    rgbdr_stream_if.sink   i_item,
    rgbdr_stream_if.source o_result,
    input  wire logic      i_cfg_we,
    input  wire t_cfg_idx  i_cfg_idx,
    input  wire t_rate     i_cfg_data
);

    localparam int PROD_W = STEP_BITS + RATE_BITS;
    localparam int INC_W  = PROD_W - STEP_FRAC_BITS;
    localparam int SUM_W  = INC_W + 1;

    t_rate r_rate_red, r_rate_green, r_rate_blue;
    t_duty r_red, r_green, r_blue;
    t_chan r_active;
    t_mode r_mode;
    t_duty r_target;
    t_step r_step;

    logic      r_out_valid;
    t_out_item r_out;

    t_duty n_red, n_green, n_blue;
    t_chan n_active;
    t_mode n_mode;
    t_duty n_target;
    t_step n_step;
    logic  n_done;

    logic              in_acc;
    t_in_item          item;
    t_duty             cur;
    t_rate             rate;
    logic [PROD_W-1:0] prod;
    logic [INC_W-1:0]  inc;
    logic [SUM_W-1:0]  sum;
    t_duty             diff;
    t_duty             nxt;
    logic              tick_done;

    assign item   = i_item.data;
    assign i_item.ready = !r_out_valid || o_result.ready;
    assign in_acc = i_item.valid && i_item.ready;

    // Pick the level and rate of the active channel.
    always_comb begin
        case (r_active)
            CH_RED: begin
                cur  = r_red;
                rate = r_rate_red;
            end
            CH_GREEN: begin
                cur  = r_green;
                rate = r_rate_green;
            end
            CH_BLUE: begin
                cur  = r_blue;
                rate = r_rate_blue;
            end
            default: begin
                cur  = '0;
                rate = '0;
            end
        endcase
    end

    assign prod = PROD_W'(r_step) * PROD_W'(rate);
    assign inc  = prod[PROD_W-1:STEP_FRAC_BITS];
    assign sum  = SUM_W'(cur) + SUM_W'(inc);
    assign diff = cur - r_target;

    always_comb begin
        nxt       = cur;
        tick_done = 1'b0;
        case (r_mode)
            MODE_STOP: begin
                if (cur != '0) begin
                    nxt       = '0;
                    tick_done = 1'b1;
                end
            end
            MODE_UP: begin
                if (cur < r_target) begin
                    if (sum >= SUM_W'(r_target)) begin
                        nxt       = r_target;
                        tick_done = 1'b1;
                    end else begin
                        nxt = sum[DUTY_BITS-1:0];
                    end
                end
            end
            MODE_DOWN: begin
                if (cur >= r_target) begin
                    if (inc >= INC_W'(diff)) begin
                        nxt       = r_target;
                        tick_done = 1'b1;
                    end else begin
                        nxt = cur - inc[DUTY_BITS-1:0];
                    end
                end
            end
            default: begin
                // unused mode: idle with the channel still active
                nxt       = cur;
                tick_done = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_red    = r_red;
        n_green  = r_green;
        n_blue   = r_blue;
        n_active = r_active;
        n_mode   = r_mode;
        n_target = r_target;
        n_step   = r_step;
        n_done   = 1'b0;
        if (item.operation == OP_START) begin
            n_active = item.channel;
            n_mode   = item.mode;
            n_target = item.target;
            n_step   = item.step_size;
        end else if (r_active != CH_NONE) begin
            case (r_active)
                CH_RED:   n_red   = nxt;
                CH_GREEN: n_green = nxt;
                default:  n_blue  = nxt;
            endcase
            n_done = tick_done;
            if (tick_done) begin
                n_active = CH_NONE;
                n_step   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_red   <= '0;
            r_rate_green <= '0;
            r_rate_blue  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RATE_RED:   r_rate_red   <= i_cfg_data;
                CFG_RATE_GREEN: r_rate_green <= i_cfg_data;
                CFG_RATE_BLUE:  r_rate_blue  <= i_cfg_data;
                default: ; // drop writes beyond the register list
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red       <= RED_RESET;
            r_green     <= '0;
            r_blue      <= '0;
            r_active    <= CH_NONE;
            r_mode      <= MODE_STOP;
            r_target    <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_red       <= n_red;
                r_green     <= n_green;
                r_blue      <= n_blue;
                r_active    <= n_active;
                r_mode      <= n_mode;
                r_target    <= n_target;
                r_step      <= n_step;
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; hold while stalled.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out.duty_red   <= n_red;
            r_out.duty_green <= n_green;
            r_out.duty_blue  <= n_blue;
            r_out.busy_res   <= (n_active != CH_NONE);
            r_out.finished   <= n_done;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

    `RGBDR_ASSERT(a_finish_not_busy, r_out_valid && r_out.finished |-> !r_out.busy_res, "finished beat still reports busy")
    `RGBDR_ASSERT(a_start_arms, in_acc && item.operation == OP_START && item.channel != CH_NONE |=> r_active != CH_NONE, "start beat did not arm a channel")
    `RGBDR_ASSERT(a_idle_tick_holds, in_acc && item.operation == OP_TICK && r_active == CH_NONE |=> $stable(r_red) && $stable(r_green) && $stable(r_blue), "idle tick moved a duty level")
    `RGBDR_ASSERT(a_empty_ready, !r_out_valid |-> i_item.ready, "input stalled with empty result register")

endmodule

`default_nettype wire
